// File: rtl/crp_pkg.sv
// Shared types, constants and helper functions for the circle raster painter.
// Has no dependencies; every other file but crp_ram imports it.
package crp_pkg;

  // Default values of the top-level parameters.
  localparam int MAX_DIM_DEF = 256;
  localparam int FRAC_DEF    = 8;

  // Fixed field widths.
  localparam int OP_W     = 2;
  localparam int CHAR_W   = 8;
  localparam int COORD_W  = 24;
  localparam int PIX_W    = 8;
  localparam int CFG_DIM_W = 9;

  // Radius arithmetic widths.
  localparam int R2_W     = 2 * COORD_W;
  localparam int INNER_W  = COORD_W + 1;
  localparam int INNER2_W = 2 * INNER_W;

  // Register port.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND    = 2'd2;

  localparam logic [CFG_DIM_W-1:0] CANVAS_WIDTH_RST  = 9'd256;
  localparam logic [CFG_DIM_W-1:0] CANVAS_HEIGHT_RST = 9'd256;
  localparam logic [CHAR_W-1:0]    BACKGROUND_RST    = 8'd32;

  // Shape kinds, as character codes.
  localparam logic [CHAR_W-1:0] KIND_OUTLINE = 8'h63;
  localparam logic [CHAR_W-1:0] KIND_FILLED  = 8'h43;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic setup_r;
    logic setup_in;
    logic scan_step;
    logic rd_en;
    logic load_result;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            reject;
    logic            scan_last;
    logic            pipe_busy;
  } status_t;

  function automatic int addr_bits(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

// File: rtl/crp_in_if.sv
// Request channel of the circle raster painter: valid/ready plus request fields.
// Depends on crp_pkg.
interface crp_in_if;
  import crp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic [CHAR_W-1:0]         shape_kind;
  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;
  logic signed [COORD_W-1:0] radius;
  logic [CHAR_W-1:0]         paint_char;
  logic [PIX_W-1:0]          pixel_x;
  logic [PIX_W-1:0]          pixel_y;

  modport source (
    output valid, operation, shape_kind, center_x, center_y, radius, paint_char,
           pixel_x, pixel_y,
    input  ready
  );

  modport sink (
    input  valid, operation, shape_kind, center_x, center_y, radius, paint_char,
           pixel_x, pixel_y,
    output ready
  );
endinterface

// File: rtl/crp_out_if.sv
// Result channel of the circle raster painter: valid/ready plus result fields.
// Depends on crp_pkg.
interface crp_out_if;
  import crp_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] pixel_value;
  logic              status;

  modport source (
    output valid, pixel_value, status,
    input  ready
  );

  modport sink (
    input  valid, pixel_value, status,
    output ready
  );
endinterface

// File: rtl/crp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module crp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/crp_ctrl.sv
// Controller state machine of the circle raster painter.
// Depends on crp_pkg; drives crp_dp through cmd_t and reads its status_t.
module crp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  crp_pkg::status_t st,
  output crp_pkg::cmd_t    cmd
);
  import crp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SETUP_R,
    S_SETUP_IN,
    S_SCAN,
    S_DRAIN,
    S_READ,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (st.op)
          OP_CLEAR: state_nxt = S_SCAN;
          OP_DRAW:  state_nxt = st.reject ? S_FINISH : S_SETUP_R;
          OP_READ:  state_nxt = S_READ;
          default:  state_nxt = S_FINISH;
        endcase
      end
      S_SETUP_R: begin
        cmd.setup_r = 1'b1;
        state_nxt   = S_SETUP_IN;
      end
      S_SETUP_IN: begin
        cmd.setup_in = 1'b1;
        state_nxt    = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!st.pipe_busy) begin
          state_nxt = S_FINISH;
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_result = 1'b1;
          out_valid_nxt   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // The pixel pipeline is always empty when a new request can be taken.
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !st.pipe_busy)
    else $error("pipeline still busy while accepting a request");

  // A result is never loaded over one that is still waiting to be taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_result |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");

  // The last scan step hands over to draining the pipeline.
  a_last_step_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_step && st.scan_last) |=> (state_r == S_DRAIN))
    else $error("scan did not end after its last pixel");

  // A rejected draw never starts a scan.
  a_reject_no_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECODE && st.op == OP_DRAW && st.reject) |=> !cmd.scan_step)
    else $error("rejected draw started a scan");

endmodule

// File: rtl/crp_dp.sv
// Datapath of the circle raster painter: request registers, scan counters,
// the three-stage distance pipeline and the result registers. Depends on crp_pkg.
module crp_dp #(
  parameter int MAX_DIM         = crp_pkg::MAX_DIM_DEF,
  parameter int COORD_FRAC_BITS = crp_pkg::FRAC_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  crp_pkg::cmd_t                            cmd,
  output crp_pkg::status_t                         st,
  input  logic [crp_pkg::OP_W-1:0]                 operation,
  input  logic [crp_pkg::CHAR_W-1:0]               shape_kind,
  input  logic signed [crp_pkg::COORD_W-1:0]       center_x,
  input  logic signed [crp_pkg::COORD_W-1:0]       center_y,
  input  logic signed [crp_pkg::COORD_W-1:0]       radius,
  input  logic [crp_pkg::CHAR_W-1:0]               paint_char,
  input  logic [crp_pkg::PIX_W-1:0]                pixel_x,
  input  logic [crp_pkg::PIX_W-1:0]                pixel_y,
  input  logic [crp_pkg::CFG_DIM_W-1:0]            canvas_width,
  input  logic [crp_pkg::CFG_DIM_W-1:0]            canvas_height,
  input  logic [crp_pkg::CHAR_W-1:0]               background_char,
  output logic                                     ram_we,
  output logic [crp_pkg::addr_bits(MAX_DIM*MAX_DIM)-1:0] ram_waddr,
  output logic [crp_pkg::CHAR_W-1:0]               ram_wdata,
  output logic                                     ram_re,
  output logic [crp_pkg::addr_bits(MAX_DIM*MAX_DIM)-1:0] ram_raddr,
  input  logic [crp_pkg::CHAR_W-1:0]               ram_rdata,
  output logic [crp_pkg::CHAR_W-1:0]               pixel_value,
  output logic                                     status
);
  import crp_pkg::*;

  localparam int ADDR_W = addr_bits(MAX_DIM * MAX_DIM);
  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int CMP_W  = (DIM_W > CFG_DIM_W) ? DIM_W : CFG_DIM_W;
  localparam int ONE    = 1 << COORD_FRAC_BITS;
  localparam int XS_W   = IDX_W + COORD_FRAC_BITS + 1;
  localparam int DX_W   = ((XS_W > COORD_W) ? XS_W : COORD_W) + 1;
  localparam int SQ_W   = 2 * DX_W;
  localparam int D_W    = (SQ_W + 1 > INNER2_W) ? SQ_W + 1 : INNER2_W;

  // Request registers.
  logic [OP_W-1:0]           op_r;
  logic [CHAR_W-1:0]         kind_r;
  logic signed [COORD_W-1:0] cx_r;
  logic signed [COORD_W-1:0] cy_r;
  logic signed [COORD_W-1:0] radius_r;
  logic [CHAR_W-1:0]         paint_r;
  logic [PIX_W-1:0]          px_r;
  logic [PIX_W-1:0]          py_r;

  // Radius bounds.
  logic [R2_W-1:0]           r2_r;
  logic signed [INNER_W-1:0] inner_r;
  logic [INNER2_W-1:0]       inner2_r;
  logic signed [R2_W-1:0]    r2_s;
  logic signed [INNER2_W-1:0] inner2_s;

  // Scan position.
  logic [IDX_W-1:0]  x_r, x_nxt;
  logic [IDX_W-1:0]  y_r, y_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;

  // Pipeline stages.
  logic                   va_r, vb_r;
  logic signed [DX_W-1:0] dx_a_r, dy_a_r;
  logic [ADDR_W-1:0]      addr_a_r, addr_b_r;
  logic [SQ_W-1:0]        dx2_r, dy2_r;
  logic signed [SQ_W-1:0] dx2_s, dy2_s;
  logic signed [DX_W-1:0] xs, ys, dx_nxt, dy_nxt;

  logic [CMP_W-1:0] w_ext, h_ext, w_eff, h_eff;
  logic             last_col, last_row, in_bounds;
  logic             kind_ok, filled, clear_mode;
  logic [D_W-1:0]   d2;
  logic             in_circle, on_ring, hit;
  logic [CHAR_W-1:0] pixel_value_r;
  logic             status_r;

  // Effective canvas size: zero acts as one, anything above MAX_DIM as MAX_DIM.
  assign w_ext = CMP_W'(canvas_width);
  assign h_ext = CMP_W'(canvas_height);
  assign w_eff = (w_ext == '0) ? CMP_W'(1) :
                 ((w_ext > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM) : w_ext);
  assign h_eff = (h_ext == '0) ? CMP_W'(1) :
                 ((h_ext > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM) : h_ext);

  assign kind_ok    = (kind_r == KIND_OUTLINE) || (kind_r == KIND_FILLED);
  assign filled     = (kind_r == KIND_FILLED);
  assign clear_mode = (op_r == OP_CLEAR);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= operation;
      kind_r   <= shape_kind;
      cx_r     <= center_x;
      cy_r     <= center_y;
      radius_r <= radius;
      paint_r  <= paint_char;
      px_r     <= pixel_x;
      py_r     <= pixel_y;
    end
  end

  assign r2_s     = radius_r * radius_r;
  assign inner2_s = inner_r * inner_r;

  always_ff @(posedge clk) begin
    if (cmd.setup_r) begin
      r2_r    <= $unsigned(r2_s);
      inner_r <= INNER_W'(radius_r) - INNER_W'(ONE);
    end
    if (cmd.setup_in) begin
      inner2_r <= $unsigned(inner2_s);
    end
  end

  // Raster scan; the position wraps to the origin after the last pixel.
  assign last_col = ((CMP_W'(x_r) + CMP_W'(1)) == w_eff);
  assign last_row = ((CMP_W'(y_r) + CMP_W'(1)) == h_eff);

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    base_nxt = base_r;
    if (cmd.scan_step) begin
      if (last_col) begin
        x_nxt = '0;
        if (last_row) begin
          y_nxt    = '0;
          base_nxt = '0;
        end else begin
          y_nxt    = y_r + IDX_W'(1);
          base_nxt = base_r + ADDR_W'(MAX_DIM);
        end
      end else begin
        x_nxt = x_r + IDX_W'(1);
      end
    end
  end

  // Stage A: offsets from the center in fixed point.
  assign xs     = DX_W'(x_r) << COORD_FRAC_BITS;
  assign ys     = DX_W'(y_r) << COORD_FRAC_BITS;
  assign dx_nxt = xs - DX_W'(cx_r);
  assign dy_nxt = ys - DX_W'(cy_r);

  // Stage B: squares.
  assign dx2_s = dx_a_r * dx_a_r;
  assign dy2_s = dy_a_r * dy_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r    <= '0;
      y_r    <= '0;
      base_r <= '0;
      va_r   <= 1'b0;
      vb_r   <= 1'b0;
    end else begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      base_r <= base_nxt;
      va_r   <= cmd.scan_step;
      vb_r   <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    dx_a_r   <= dx_nxt;
    dy_a_r   <= dy_nxt;
    addr_a_r <= base_r + ADDR_W'(x_r);
    dx2_r    <= $unsigned(dx2_s);
    dy2_r    <= $unsigned(dy2_s);
    addr_b_r <= addr_a_r;
  end

  // Stage C: compare against the squared bounds and write.
  assign d2        = D_W'(dx2_r) + D_W'(dy2_r);
  assign in_circle = (d2 <= D_W'(r2_r));
  assign on_ring   = filled || inner_r[INNER_W-1] || (d2 > D_W'(inner2_r));
  assign hit       = clear_mode || (in_circle && on_ring);

  assign ram_we    = vb_r && hit;
  assign ram_waddr = addr_b_r;
  assign ram_wdata = clear_mode ? background_char : paint_r;

  // Pixel read.
  assign in_bounds = (CMP_W'(px_r) < w_eff) && (CMP_W'(py_r) < h_eff);
  assign ram_re    = cmd.rd_en;
  assign ram_raddr = ADDR_W'(py_r) * ADDR_W'(MAX_DIM) + ADDR_W'(px_r);

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      pixel_value_r <= ((op_r == OP_READ) && in_bounds) ? ram_rdata : '0;
      status_r      <= (op_r == OP_DRAW) && (radius_r <= 0 || !kind_ok);
    end
  end

  assign pixel_value = pixel_value_r;
  assign status      = status_r;

  assign st.op        = op_r;
  assign st.reject    = (radius_r <= 0) || !kind_ok;
  assign st.scan_last = last_col && last_row;
  assign st.pipe_busy = va_r || vb_r;

endmodule

// File: rtl/circle_raster_painter.sv
// Top level of the circle raster painter: register port, controller, datapath
// and canvas RAM. Depends on crp_pkg, crp_in_if, crp_out_if, crp_ram, crp_ctrl, crp_dp.
//
// Usage. Requests arrive on in_req (valid/ready) and each one produces exactly
// one result on out_rsp (valid/ready). Operation 0 clears the canvas to the
// background byte, 1 draws a filled ('C') or outline ('c') circle given in signed
// fixed point, 2 reads one pixel. A draw with a radius that is not positive or
// an unknown kind returns status 1 and leaves the canvas alone.
// Timing. One request is worked on at a time. Clear and draw visit every
// pixel of the active width by height area, one pixel per cycle; the scan
// counter and the single write port of the canvas RAM set that rate.
// The canvas has no reset: it must be cleared before it is read.
// Reset (rst_n low, synchronous) returns the registers to width 256, height 256,
// background 0x20, empties the pipeline and drops out_rsp.valid.
// A stalled receiver holds the result in the output register; the block still takes
// the next request and stops before delivering its result until the waiting one is
// taken. The user must write registers only while the block is idle; it is unchecked.
module circle_raster_painter #(
  parameter int MAX_DIM         = crp_pkg::MAX_DIM_DEF,
  parameter int COORD_FRAC_BITS = crp_pkg::FRAC_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  crp_in_if.sink                           in_req,
  crp_out_if.source                        out_rsp,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [crp_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [crp_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [crp_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import crp_pkg::*;

  localparam int ADDR_W = addr_bits(MAX_DIM * MAX_DIM);

  logic [CFG_DIM_W-1:0] canvas_width_r;
  logic [CFG_DIM_W-1:0] canvas_height_r;
  logic [CHAR_W-1:0]    background_r;
  logic [CFG_IDX_W-1:0] reg_idx;
  logic                 reg_wr;

  cmd_t    cmd;
  status_t st;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CHAR_W-1:0] ram_wdata, ram_rdata;

  // Register port: the write lands at the access phase; the port never waits.
  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_IDX_W+1:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canvas_width_r  <= CANVAS_WIDTH_RST;
      canvas_height_r <= CANVAS_HEIGHT_RST;
      background_r    <= BACKGROUND_RST;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_CANVAS_WIDTH:  canvas_width_r  <= pwdata[CFG_DIM_W-1:0];
        REG_CANVAS_HEIGHT: canvas_height_r <= pwdata[CFG_DIM_W-1:0];
        REG_BACKGROUND:    background_r    <= pwdata[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  // Reads return the raw register bits, as written.
  always_comb begin
    unique case (reg_idx)
      REG_CANVAS_WIDTH:  prdata = CFG_DATA_W'(canvas_width_r);
      REG_CANVAS_HEIGHT: prdata = CFG_DATA_W'(canvas_height_r);
      REG_BACKGROUND:    prdata = CFG_DATA_W'(background_r);
      default:           prdata = '0;
    endcase
  end

  // Sequencing of each request.
  crp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // Arithmetic, scan position and result registers.
  crp_dp #(
    .MAX_DIM         (MAX_DIM),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .operation       (in_req.operation),
    .shape_kind      (in_req.shape_kind),
    .center_x        (in_req.center_x),
    .center_y        (in_req.center_y),
    .radius          (in_req.radius),
    .paint_char      (in_req.paint_char),
    .pixel_x         (in_req.pixel_x),
    .pixel_y         (in_req.pixel_y),
    .canvas_width    (canvas_width_r),
    .canvas_height   (canvas_height_r),
    .background_char (background_r),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_re          (ram_re),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata),
    .pixel_value     (out_rsp.pixel_value),
    .status          (out_rsp.status)
  );

  // Canvas: pixel (x, y) lives at y*MAX_DIM + x.
  crp_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_DIM * MAX_DIM)
  ) u_canvas (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// File: test/tb_circle_raster_painter.sv
`timescale 1ns / 100ps
// Self-checking testbench for circle_raster_painter: directed and random requests
// against a built-in canvas predictor. Depends on crp_pkg, crp_in_if, crp_out_if and the RTL.
module tb_circle_raster_painter;
  import crp_pkg::*;

  localparam int DIM  = MAX_DIM_DEF;
  localparam int FRAC = FRAC_DEF;

  // Operation code 3 has no meaning; the block must answer it with zeros.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // A kind byte that is neither outline nor filled ('A').
  localparam logic [CHAR_W-1:0] KIND_BOGUS = 8'h41;
  // Length of the deliberate receiver hold-off, in clock cycles.
  localparam int LONG_HOLD = 150;

  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic [CHAR_W-1:0]         shape_kind;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] radius;
    logic [CHAR_W-1:0]         paint_char;
    logic [PIX_W-1:0]          pixel_x;
    logic [PIX_W-1:0]          pixel_y;
  } painter_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] pixel_value;
    logic              status;
  } painter_rsp_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  crp_in_if  in_req ();
  crp_out_if out_rsp ();

  circle_raster_painter u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: our own copy of the canvas and of the three registers.
  logic [CHAR_W-1:0]    canvas_mem [DIM*DIM];
  logic [CFG_DIM_W-1:0] width_reg  = CANVAS_WIDTH_RST;
  logic [CFG_DIM_W-1:0] height_reg = CANVAS_HEIGHT_RST;
  logic [CHAR_W-1:0]    bg_reg     = BACKGROUND_RST;

  // Results predicted for accepted requests, oldest first.
  painter_rsp_t awaited_results [$];

  int error_count   = 0;
  bit idle_on       = 1'b0;
  int hold_requests = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH at %0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  // A raw width or height of 0 behaves as 1, anything above the canvas size as
  // the canvas size. The raw bits are what a register read returns.
  function automatic int unsigned effective_dim(input logic [CFG_DIM_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > DIM) return DIM;
    return raw;
  endfunction

  // Applies one request to the predicted canvas and returns the result the
  // block must give for it. All distances are compared squared, in exact
  // 64-bit integer arithmetic on the fixed-point values.
  function automatic painter_rsp_t canvas_apply(input painter_req_t q);
    painter_rsp_t res;
    int unsigned  w;
    int unsigned  h;
    longint       one;
    longint       rad;
    longint       r2;
    longint       inner;
    longint       inner2;
    longint       dx;
    longint       dy;
    longint       d2;
    res = '0;
    w   = effective_dim(width_reg);
    h   = effective_dim(height_reg);
    one = longint'(1) << FRAC;
    case (q.operation)
      OP_CLEAR: begin
        for (int y = 0; y < h; y++)
          for (int x = 0; x < w; x++)
            canvas_mem[y*DIM + x] = bg_reg;
      end
      OP_DRAW: begin
        rad = q.radius;
        if (rad <= 0 || (q.shape_kind != KIND_OUTLINE && q.shape_kind != KIND_FILLED)) begin
          res.status = 1'b1;
        end else begin
          r2     = rad * rad;
          inner  = rad - one;
          inner2 = inner * inner;
          for (int y = 0; y < h; y++) begin
            dy = longint'(y) * one - longint'(q.center_y);
            for (int x = 0; x < w; x++) begin
              dx = longint'(x) * one - longint'(q.center_x);
              d2 = dx * dx + dy * dy;
              // The outline keeps only the ring beyond r - 1; when r is below
              // one pixel the whole disc counts as outline.
              if (d2 <= r2 &&
                  (q.shape_kind == KIND_FILLED || inner < 0 || d2 > inner2))
                canvas_mem[y*DIM + x] = q.paint_char;
            end
          end
        end
      end
      OP_READ: begin
        if (q.pixel_x < w && q.pixel_y < h)
          res.pixel_value = canvas_mem[int'(q.pixel_y)*DIM + int'(q.pixel_x)];
      end
      default: ;
    endcase
    return res;
  endfunction

  // Random request shaped for the current canvas: most centers and radii land
  // near the canvas so that draws actually paint, a few use the whole range.
  // Fields an operation ignores still carry random bits.
  function automatic painter_req_t random_req();
    painter_req_t q;
    int unsigned  w;
    int unsigned  h;
    int unsigned  span;
    int unsigned  pick;
    w = effective_dim(width_reg);
    h = effective_dim(height_reg);
    span = (w > h) ? w : h;
    q.operation  = 2'($urandom);
    q.shape_kind = 8'($urandom);
    q.center_x   = 24'($urandom);
    q.center_y   = 24'($urandom);
    q.radius     = 24'($urandom);
    q.paint_char = 8'($urandom);
    q.pixel_x    = 8'($urandom);
    q.pixel_y    = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      q.operation = OP_CLEAR;
    end else if (pick < 60) begin
      q.operation = OP_DRAW;
      if ($urandom_range(0, 6) != 0)
        q.shape_kind = $urandom_range(0, 1) ? KIND_FILLED : KIND_OUTLINE;
      if ($urandom_range(0, 4) != 0) begin
        q.center_x = 24'(int'($urandom_range(0, (w + 8) * 256)) - 4 * 256);
        q.center_y = 24'(int'($urandom_range(0, (h + 8) * 256)) - 4 * 256);
      end
      case ($urandom_range(0, 9))
        0: ;  // keep the full-range random radius
        1: q.radius = 24'(-int'($urandom_range(0, 2000)));
        default: q.radius = 24'($urandom_range(1, (span + 2) * 256));
      endcase
    end else if (pick < 95) begin
      q.operation = OP_READ;
      if ($urandom_range(0, 4) != 0) begin
        q.pixel_x = 8'($urandom_range(0, w - 1));
        q.pixel_y = 8'($urandom_range(0, h - 1));
      end
    end else begin
      q.operation = OP_UNUSED;
    end
    return q;
  endfunction

  // Offers one request and waits for it to be taken. Valid stays high after
  // the handshake; the next call either replaces the request or opens a gap,
  // and drain_block drops it, so valid is written once per falling edge.
  task automatic send_req(input painter_req_t q);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      in_req.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req.valid      = 1'b1;
    in_req.operation  = q.operation;
    in_req.shape_kind = q.shape_kind;
    in_req.center_x   = q.center_x;
    in_req.center_y   = q.center_y;
    in_req.radius     = q.radius;
    in_req.paint_char = q.paint_char;
    in_req.pixel_x    = q.pixel_x;
    in_req.pixel_y    = q.pixel_y;
    do @(posedge clk); while (!in_req.ready);
    awaited_results.push_back(canvas_apply(q));
  endtask

  task automatic send_plain(input logic [OP_W-1:0] op);
    painter_req_t q;
    q = random_req();
    q.operation = op;
    send_req(q);
  endtask

  task automatic send_read(input int x, input int y);
    painter_req_t q;
    q = random_req();
    q.operation = OP_READ;
    q.pixel_x   = 8'(x);
    q.pixel_y   = 8'(y);
    send_req(q);
  endtask

  task automatic send_draw(input logic [CHAR_W-1:0] kind, input logic signed [COORD_W-1:0] cx,
                           input logic signed [COORD_W-1:0] cy,
                           input logic signed [COORD_W-1:0] rad, input logic [CHAR_W-1:0] paint);
    painter_req_t q;
    q = random_req();
    q.operation  = OP_DRAW;
    q.shape_kind = kind;
    q.center_x   = cx;
    q.center_y   = cy;
    q.radius     = rad;
    q.paint_char = paint;
    send_req(q);
  endtask

  // Drops valid, waits for every predicted result, then lets the pipeline
  // settle so that register writes land on an idle block.
  task automatic drain_block();
    @(negedge clk);
    in_req.valid = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // One register transfer: setup cycle, then access cycle until pready.
  task automatic apb_cycle(input bit is_write, input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data, output logic [CFG_DATA_W-1:0] rdata);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = is_write;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] want);
    logic [CFG_DATA_W-1:0] readback;
    apb_cycle(1'b0, idx, '0, readback);
    if (readback !== want) report_mismatch($sformatf("register %0d readback", idx), readback, want);
  endtask

  // Writes a register, mirrors the raw bits into the predictor and reads
  // them back.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] unused_rd;
    apb_cycle(1'b1, idx, value, unused_rd);
    case (idx)
      REG_CANVAS_WIDTH:  width_reg  = value[CFG_DIM_W-1:0];
      REG_CANVAS_HEIGHT: height_reg = value[CFG_DIM_W-1:0];
      REG_BACKGROUND:    bg_reg     = value[CHAR_W-1:0];
      default: ;
    endcase
    check_register(idx, (idx == REG_BACKGROUND) ? (value & 32'hFF) : (value & 32'h1FF));
  endtask

  // Full-size canvas with the reset register values: a clear and a large
  // filled disc over all 256 by 256 pixels.
  task automatic test_reset_defaults();
    check_register(REG_CANVAS_WIDTH, 32'(CANVAS_WIDTH_RST));
    check_register(REG_CANVAS_HEIGHT, 32'(CANVAS_HEIGHT_RST));
    check_register(REG_BACKGROUND, 32'(BACKGROUND_RST));
    send_plain(OP_CLEAR);
    send_read(0, 0);
    send_read(255, 255);
    // Center (127.5, 128.0), radius 90.25.
    send_draw(KIND_FILLED, 24'sd32640, 24'sd32768, 24'sd23104, 8'h58);
    send_read(127, 128);
    send_read(0, 0);
  endtask

  // Register extremes: a 0 by 0 setting acts as a single pixel, and a width
  // beyond the canvas acts as the full width.
  task automatic test_register_extremes();
    drain_block();
    write_register(REG_CANVAS_WIDTH, 32'd0);
    write_register(REG_CANVAS_HEIGHT, 32'd0);
    write_register(REG_BACKGROUND, 32'd0);
    send_plain(OP_CLEAR);
    send_read(0, 0);
    send_read(1, 0);   // outside the one-pixel canvas
    send_draw(KIND_FILLED, 24'sd0, 24'sd0, 24'sd256, 8'hFF);
    send_read(0, 0);

    drain_block();
    write_register(REG_CANVAS_WIDTH, 32'd511);
    write_register(REG_CANVAS_HEIGHT, 32'd2);
    write_register(REG_BACKGROUND, 32'd255);
    send_plain(OP_CLEAR);
    // Outline with radius 0.5: below one pixel, so the whole disc is outline.
    send_draw(KIND_OUTLINE, 24'sd768, 24'sd256, 24'sd128, 8'h6F);
    send_read(3, 1);
    send_read(4, 1);
    // Largest radius with the center at the largest column: the far edge
    // of the circle touches pixel (0, 0) exactly.
    send_draw(KIND_FILLED, 24'sh7FFFFF, 24'sd0, 24'sh7FFFFF, 8'h01);
    send_read(0, 0);
    send_read(0, 1);
  endtask

  // Draws that must be refused, and the unused operation code; the pixel
  // under their centers must keep its value.
  task automatic test_rejected_requests();
    send_draw(KIND_FILLED, 24'sd768, 24'sd256, 24'sd0, 8'h11);
    send_draw(KIND_OUTLINE, 24'sd768, 24'sd256, -24'sd256, 8'h22);
    send_draw(KIND_FILLED, 24'sd768, 24'sd256, 24'sh800000, 8'h33);
    send_draw(KIND_BOGUS, 24'sd768, 24'sd256, 24'sd256, 8'h44);
    send_draw(8'hFF, 24'sd768, 24'sd256, 24'sd256, 8'h55);
    send_plain(OP_UNUSED);
    send_read(3, 1);
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so
  // the output register fills and the block stops taking requests.
  task automatic test_output_backpressure();
    drain_block();
    idle_on = 1'b0;
    write_register(REG_CANVAS_WIDTH, 32'd6);
    write_register(REG_CANVAS_HEIGHT, 32'd5);
    write_register(REG_BACKGROUND, 32'h2E);
    send_plain(OP_CLEAR);
    hold_requests++;
    repeat (8) send_req(random_req());
  endtask

  // Random phases on small canvases, each opened by a clear so that every
  // pixel in use has been written before it can be read. The last phase runs
  // without any idling.
  task automatic test_random_phases();
    int wraw;
    int hraw;
    for (int phase = 0; phase < 5; phase++) begin
      drain_block();
      idle_on = (phase < 4) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) == 0) begin
        wraw = $urandom_range(257, 511);
        hraw = $urandom_range(0, 2);
      end else begin
        wraw = $urandom_range(0, 20);
        hraw = $urandom_range(1, 20);
      end
      write_register(REG_CANVAS_WIDTH, 32'(wraw));
      write_register(REG_CANVAS_HEIGHT, 32'(hraw));
      write_register(REG_BACKGROUND, 32'($urandom_range(0, 255)));
      send_plain(OP_CLEAR);
      repeat (13) send_req(random_req());
    end
  endtask

  // Result receiver. Random stall bursts while idling is on; a long hold-off
  // each time the backpressure test asks for one.
  initial begin
    int hold_cnt;
    int stall_cnt;
    int holds_seen;
    hold_cnt      = 0;
    stall_cnt     = 0;
    holds_seen    = 0;
    out_rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        hold_cnt   = LONG_HOLD;
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        out_rsp.ready = 1'b0;
      end else if (stall_cnt != 0) begin
        stall_cnt--;
        out_rsp.ready = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_cnt     = $urandom_range(0, 17);
        out_rsp.ready = 1'b0;
      end else begin
        out_rsp.ready = 1'b1;
      end
    end
  end

  // Every delivered result is matched against the oldest prediction.
  always @(posedge clk) begin
    painter_rsp_t want;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result with no request pending", {out_rsp.pixel_value, out_rsp.status}, 0);
      end else begin
        want = awaited_results.pop_front();
        if (out_rsp.pixel_value !== want.pixel_value)
          report_mismatch("pixel_value", out_rsp.pixel_value, want.pixel_value);
        if (out_rsp.status !== want.status)
          report_mismatch("status", out_rsp.status, want.status);
      end
    end
  end

  initial begin
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_req.valid      = 1'b0;
    in_req.operation  = OP_CLEAR;
    in_req.shape_kind = '0;
    in_req.center_x   = '0;
    in_req.center_y   = '0;
    in_req.radius     = '0;
    in_req.paint_char = '0;
    in_req.pixel_x    = '0;
    in_req.pixel_y    = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_register_extremes();
    test_rejected_requests();
    test_output_backpressure();
    test_random_phases();
    drain_block();

    if (error_count == 0) begin
      $display("** circle_raster_painter: PASSED **");
    end else begin
      $display("** circle_raster_painter: FAILED **");
    end
    $finish;
  end

  // A correct run is dominated by the two full-canvas scans; this timeout
  // leaves ample room beyond them.
  initial begin
    #20000000;
    $display("** circle_raster_painter: FAILED **");
    $finish;
  end

endmodule
